>>> hw/rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// types and constants shared by the tag presence tracker modules
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

	// presence machine states
	typedef enum logic [1:0] {
		ST_ABSENT   = 2'd0,
		ST_DETECTED = 2'd1,
		ST_PRESENT  = 2'd2,
		ST_REMOVED  = 2'd3
	} presence_state_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_READER_ENABLED      = 2'd0,
		CFG_DEBOUNCE_MS         = 2'd1,
		CFG_PRESENCE_FAIL_LIMIT = 2'd2,
		CFG_ABSENCE_TIMEOUT_MS  = 2'd3
	} cfg_index_t;

	localparam int CFG_DATA_W = 16;

	// misses tolerated while detected before falling back to absent
	localparam logic [7:0] DETECT_MISS_LIMIT = 8'd2;
	localparam logic [7:0] MISS_COUNT_MAX    = 8'hFF;

	// configuration reset values
	localparam logic        RST_READER_ENABLED      = 1'b0;
	localparam logic [15:0] RST_DEBOUNCE_MS         = 16'd100;
	localparam logic [7:0]  RST_PRESENCE_FAIL_LIMIT = 8'd3;
	localparam logic [15:0] RST_ABSENCE_TIMEOUT_MS  = 16'd500;

	// one poll beat
	typedef struct packed {
		logic        tag_seen;
		logic [3:0]  uid_length;
		logic [63:0] uid_low;
		logic [15:0] uid_high;
		logic [31:0] now_ms;
	} poll_t;

	// one result beat
	typedef struct packed {
		logic [1:0] presence;
		logic       read_request;
		logic       uid_cleared;
		logic [3:0] stored_uid_length;
	} result_t;

	// live configuration
	typedef struct packed {
		logic        reader_enabled;
		logic [15:0] debounce_ms;
		logic [7:0]  presence_fail_limit;
		logic [15:0] absence_timeout_ms;
	} cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/tag_presence_tracker_top.sv
// ----------------------------------------------------------------------------
// tag_presence_tracker_top
// tracks a tag in front of a reader from a stream of poll results
// ----------------------------------------------------------------------------
//
//   channel   handshake                 beat
//   -------   -----------------------   --------------------------------------
//   poll      poll_valid / poll_stall   poll_t: seen flag, uid, length, time
//   result    result_valid / result_    result_t: state, read request,
//             stall                     cleared flag, stored length
//   cfg       cfg_valid / cfg_ready     register index and write data
//
// one poll beat per cycle sustained while the result side does not stall; a poll
// taken into the input register passes to the result register (state update and
// result) when the tracker takes it, and its result beat is handed on from there
// the state update is one pass of short logic: a 32-bit time difference and
// compare, and an identifier compare masked to the clamped length
// reset clears the presence state, stored identifier, timestamps, miss count
// and the configuration to its defaults; no sweep is needed after reset
// a stalled result holds the input register, which then stalls the poll side
// cfg_ready is always high; writes take effect on the next beat processed
// ----------------------------------------------------------------------------
`default_nettype none

module tag_presence_tracker_top
	import tpt_pkg::*;
#(
	parameter int MAX_UID_BYTES = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// poll beats in
	input  wire logic                  poll_valid,
	output logic                       poll_stall,
	input  wire poll_t                 poll,
	// result beats out
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	logic  valid_s1;
	poll_t poll_s1;
	logic  take;

	// register bank
	tpt_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register, drains whenever the tracker takes its beat
	tpt_poll_stage u_poll_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll_valid),
		.poll_stall (poll_stall),
		.poll       (poll),
		.take       (take),
		.valid_s1   (valid_s1),
		.poll_s1    (poll_s1)
	);

	// presence machine; state advances only when a result beat is written
	tpt_tracker #(
		.MAX_UID_BYTES (MAX_UID_BYTES)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.valid_s1     (valid_s1),
		.poll_s1      (poll_s1),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> hw/rtl/tpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpt_cfg_regs
// configuration register bank, written one register per beat
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_cfg_regs
	import tpt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reader_enabled      <= RST_READER_ENABLED;
			cfg_q.debounce_ms         <= RST_DEBOUNCE_MS;
			cfg_q.presence_fail_limit <= RST_PRESENCE_FAIL_LIMIT;
			cfg_q.absence_timeout_ms  <= RST_ABSENCE_TIMEOUT_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_READER_ENABLED:      cfg_q.reader_enabled      <= cfg_data[0];
				CFG_DEBOUNCE_MS:         cfg_q.debounce_ms         <= cfg_data[15:0];
				CFG_PRESENCE_FAIL_LIMIT: cfg_q.presence_fail_limit <= cfg_data[7:0];
				CFG_ABSENCE_TIMEOUT_MS:  cfg_q.absence_timeout_ms  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tpt_poll_stage.sv
// ----------------------------------------------------------------------------
// tpt_poll_stage
// input register for poll beats, refilled in the cycle it drains
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_poll_stage
	import tpt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  poll_valid,
	output logic       poll_stall,
	input  wire poll_t poll,
	input  wire logic  take,
	output logic       valid_s1,
	output poll_t      poll_s1
);

	logic load;

	// hold off only while a beat sits here and cannot move on
	assign poll_stall = valid_s1 && !take;
	assign load       = poll_valid && !poll_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			poll_s1 <= poll;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tpt_tracker.sv
// ----------------------------------------------------------------------------
// tpt_tracker
// presence state machine, stored identifier and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_tracker
	import tpt_pkg::*;
#(
	parameter int MAX_UID_BYTES = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  valid_s1,
	input  wire poll_t poll_s1,
	output logic       take,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	localparam int         UID_W   = 8 * MAX_UID_BYTES;
	localparam logic [3:0] MAX_LEN = 4'(MAX_UID_BYTES);

	presence_state_t   state_q, state_n;
	logic [UID_W-1:0]  uid_q, uid_n;
	logic [3:0]        len_q, len_n;
	logic [31:0]       last_seen_q, last_seen_n;
	logic [31:0]       first_seen_q, first_seen_n;
	logic [7:0]        miss_q, miss_n;
	logic              result_valid_q;
	result_t           result_q;

	logic [3:0]        len_c;
	logic [79:0]       uid_raw;
	logic [UID_W-1:0]  mask;
	logic [UID_W-1:0]  uid_in;
	logic              same;
	logic [7:0]        miss_inc;
	logic [31:0]       since_first;
	logic [31:0]       since_last;
	logic              timed_out;
	logic              read_req;
	logic              cleared;

	assign take         = valid_s1 && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// byte mask from the clamped length
	always_comb begin
		len_c   = (poll_s1.uid_length > MAX_LEN) ? MAX_LEN : poll_s1.uid_length;
		uid_raw = {poll_s1.uid_high, poll_s1.uid_low};
		for (int b = 0; b < MAX_UID_BYTES; b++) begin
			mask[b*8 +: 8] = {8{4'(b) < len_c}};
		end
		uid_in      = uid_raw[UID_W-1:0] & mask;
		same        = (len_q == len_c) && ((uid_q & mask) == uid_in);
		miss_inc    = (miss_q == MISS_COUNT_MAX) ? miss_q : miss_q + 8'd1;
		since_first = poll_s1.now_ms - first_seen_q;
		since_last  = poll_s1.now_ms - last_seen_q;
		timed_out   = since_last > {16'd0, cfg.absence_timeout_ms};
	end

	always_comb begin
		state_n      = state_q;
		uid_n        = uid_q;
		len_n        = len_q;
		last_seen_n  = last_seen_q;
		first_seen_n = first_seen_q;
		miss_n       = miss_q;
		read_req     = 1'b0;
		cleared      = 1'b0;
		if (cfg.reader_enabled) begin
			if (poll_s1.tag_seen) begin
				uid_n       = uid_in;
				len_n       = len_c;
				last_seen_n = poll_s1.now_ms;
				miss_n      = '0;
				case (state_q)
					ST_ABSENT: begin
						state_n      = ST_DETECTED;
						first_seen_n = poll_s1.now_ms;
					end
					ST_DETECTED: begin
						if (since_first > {16'd0, cfg.debounce_ms}) begin
							state_n  = ST_PRESENT;
							read_req = 1'b1;
						end
					end
					ST_PRESENT: begin
						// new identifier: store, then drop it straight away
						if (!same) begin
							state_n      = ST_DETECTED;
							first_seen_n = poll_s1.now_ms;
							uid_n        = '0;
							len_n        = '0;
							cleared      = 1'b1;
						end
					end
					default: begin
						state_n      = ST_DETECTED;
						first_seen_n = poll_s1.now_ms;
					end
				endcase
			end else if (state_q != ST_ABSENT) begin
				miss_n = miss_inc;
				case (state_q)
					ST_DETECTED: begin
						if (miss_inc > DETECT_MISS_LIMIT) begin
							state_n = ST_ABSENT;
							uid_n   = '0;
							len_n   = '0;
							cleared = 1'b1;
						end
					end
					ST_PRESENT: begin
						if (miss_inc >= cfg.presence_fail_limit || timed_out) begin
							state_n = ST_REMOVED;
							uid_n   = '0;
							len_n   = '0;
							cleared = 1'b1;
						end
					end
					ST_REMOVED: begin
						if (timed_out) begin
							state_n = ST_ABSENT;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ABSENT;
			uid_q          <= '0;
			len_q          <= '0;
			last_seen_q    <= '0;
			first_seen_q   <= '0;
			miss_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q        <= state_n;
				uid_q          <= uid_n;
				len_q          <= len_n;
				last_seen_q    <= last_seen_n;
				first_seen_q   <= first_seen_n;
				miss_q         <= miss_n;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.presence          <= state_n;
			result_q.read_request      <= read_req;
			result_q.uid_cleared       <= cleared;
			result_q.stored_uid_length <= len_n;
		end
	end

endmodule

`default_nettype wire

>>> sim/tb_tag_presence_tracker_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tag_presence_tracker_top
// self-checking bench for the tag presence tracker
// ----------------------------------------------------------------------------
// poll beats go in through a valid/stall sender and every result beat is
// checked field by field against a behavioural copy of the presence machine
// kept here. directed tests walk the debounce, identifier compare, miss and
// timeout paths, then several random phases run tag sessions with noise
// under different register settings and back-pressure patterns.
// ----------------------------------------------------------------------------

module tb_tag_presence_tracker_top;
	import tpt_pkg::*;

	localparam int UID_BYTES_MAX = 10;
	localparam int QUIET_LIMIT   = 2000;	// cycles with no beat on any channel
	localparam int SETTLE_CYCLES = 4;	// margin for the pipe to empty
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_POLLS   = 190;

	// dut connections, the inputs driven to known values from time zero
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  poll_valid   = 1'b0;
	logic                  poll_stall;
	poll_t                 poll         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// idling knobs, percent of cycles
	int send_idle_pct  = 9;
	int recv_stall_pct = 64;

	int fail_count = 0;

	// results still owed by the dut, oldest first
	result_t expected_results[$];

	// predictor copy of the registers
	logic        cfg_en         = RST_READER_ENABLED;
	logic [15:0] cfg_debounce   = RST_DEBOUNCE_MS;
	logic [7:0]  cfg_fail_limit = RST_PRESENCE_FAIL_LIMIT;
	logic [15:0] cfg_timeout    = RST_ABSENCE_TIMEOUT_MS;

	// predictor copy of the tracker state
	presence_state_t trk_state  = ST_ABSENT;
	logic [63:0]     held_lo    = '0;
	logic [15:0]     held_hi    = '0;
	logic [3:0]      held_len   = '0;
	logic [31:0]     last_seen  = '0;
	logic [31:0]     first_seen = '0;
	logic [7:0]      misses     = '0;

	// random session generator: running clock and the tag in front of the reader
	logic [31:0] gen_ms  = '0;
	logic [63:0] gen_lo  = '0;
	logic [15:0] gen_hi  = '0;
	logic [3:0]  gen_len = 4'd4;

	always #2 clk = ~clk;

	tag_presence_tracker_top #(
		.MAX_UID_BYTES(UID_BYTES_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll_valid   (poll_valid),
		.poll_stall   (poll_stall),
		.poll         (poll),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------------
	// presence machine predictor
	// ------------------------------------------------------------------------

	// lengths past the identifier size are treated as the full size
	function automatic logic [3:0] clamp_len(logic [3:0] n);
		return (n > UID_BYTES_MAX) ? 4'(UID_BYTES_MAX) : n;
	endfunction

	// byte masks over the low eight bytes and the top two
	function automatic logic [63:0] lo_bytes_mask(logic [3:0] n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic logic [15:0] hi_bytes_mask(logic [3:0] n);
		if (n <= 8)
			return '0;
		if (n >= 10)
			return '1;
		return (16'd1 << (8 * (n - 8))) - 16'd1;
	endfunction

	function automatic void forget_uid();
		held_lo  = '0;
		held_hi  = '0;
		held_len = '0;
	endfunction

	// advances the state by one poll and returns the result it must produce
	function automatic result_t predict_poll(poll_t p);
		result_t     r;
		logic [3:0]  len;
		logic [63:0] lo;
		logic [15:0] hi;
		logic        same;
		logic [31:0] since_first;
		logic [31:0] since_last;
		r = '0;
		if (cfg_en) begin
			len = clamp_len(p.uid_length);
			lo = p.uid_low & lo_bytes_mask(len);
			hi = p.uid_high & hi_bytes_mask(len);
			// wrapping differences, taken before any timestamp moves
			since_first = p.now_ms - first_seen;
			since_last = p.now_ms - last_seen;
			if (p.tag_seen) begin
				same = (held_len == len) && ((held_lo & lo_bytes_mask(len)) == lo) &&
					((held_hi & hi_bytes_mask(len)) == hi);
				held_lo = lo;
				held_hi = hi;
				held_len = len;
				last_seen = p.now_ms;
				misses = '0;
				case (trk_state)
					ST_ABSENT: begin
						trk_state = ST_DETECTED;
						first_seen = p.now_ms;
					end
					ST_DETECTED: begin
						if (since_first > {16'd0, cfg_debounce}) begin
							trk_state = ST_PRESENT;
							r.read_request = 1'b1;
						end
					end
					ST_PRESENT: begin
						// a new identifier is stored and then dropped straight away
						if (!same) begin
							trk_state = ST_DETECTED;
							first_seen = p.now_ms;
							forget_uid();
							r.uid_cleared = 1'b1;
						end
					end
					default: begin
						trk_state = ST_DETECTED;
						first_seen = p.now_ms;
					end
				endcase
			end else if (trk_state != ST_ABSENT) begin
				if (misses != MISS_COUNT_MAX)
					misses = misses + 8'd1;
				case (trk_state)
					ST_DETECTED: begin
						if (misses > DETECT_MISS_LIMIT) begin
							trk_state = ST_ABSENT;
							forget_uid();
							r.uid_cleared = 1'b1;
						end
					end
					ST_PRESENT: begin
						if (misses >= cfg_fail_limit || since_last > {16'd0, cfg_timeout}) begin
							trk_state = ST_REMOVED;
							forget_uid();
							r.uid_cleared = 1'b1;
						end
					end
					default: begin
						if (since_last > {16'd0, cfg_timeout})
							trk_state = ST_ABSENT;
					end
				endcase
			end
		end
		r.presence = trk_state;
		r.stored_uid_length = held_len;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------------

	function automatic poll_t mk_poll(logic seen, logic [3:0] len, logic [63:0] lo,
			logic [15:0] hi, logic [31:0] ms);
		poll_t p;
		p.tag_seen = seen;
		p.uid_length = len;
		p.uid_low = lo;
		p.uid_high = hi;
		p.now_ms = ms;
		return p;
	endfunction

	// one poll beat; returns just after the edge that took it, valid still high
	task automatic send_poll(input poll_t p);
		@(negedge clk);
		while (int'($urandom_range(0, 99)) < send_idle_pct) begin
			poll_valid <= 1'b0;
			@(negedge clk);
		end
		poll <= p;
		poll_valid <= 1'b1;
		do
			@(posedge clk);
		while (poll_stall);
		expected_results.push_back(predict_poll(p));
	endtask

	// sender holds off until every owed result is back and the pipe is empty
	task automatic wait_results_idle();
		@(negedge clk);
		poll_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, only ever issued with the tracker idle
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		wait_results_idle();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_READER_ENABLED:      cfg_en = data[0];
			CFG_DEBOUNCE_MS:         cfg_debounce = data;
			CFG_PRESENCE_FAIL_LIMIT: cfg_fail_limit = data[7:0];
			CFG_ABSENCE_TIMEOUT_MS:  cfg_timeout = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		result_stall <= (int'($urandom_range(0, 99)) < recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 50)
			$display("%0t ns: %s", $time, msg);
	endtask

	// outputs are sampled at the rising edge, before the dut's own updates land
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result beat %h with nothing expected", result));
			end else begin
				want = expected_results.pop_front();
				if (result.presence !== want.presence)
					report_mismatch($sformatf("presence %0d, expected %0d",
						result.presence, want.presence));
				if (result.read_request !== want.read_request)
					report_mismatch($sformatf("read_request %0b, expected %0b",
						result.read_request, want.read_request));
				if (result.uid_cleared !== want.uid_cleared)
					report_mismatch($sformatf("uid_cleared %0b, expected %0b",
						result.uid_cleared, want.uid_cleared));
				if (result.stored_uid_length !== want.stored_uid_length)
					report_mismatch($sformatf("stored_uid_length %0d, expected %0d",
						result.stored_uid_length, want.stored_uid_length));
			end
		end
	end

	// ends the run once no channel has moved a beat for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((poll_valid && !poll_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_tag_presence_tracker_top: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// straight out of reset the reader is off: polls must leave everything alone
	task automatic test_reader_disabled();
		send_poll(mk_poll(1'b1, 4'd4, 64'h0000_0000_DEAD_BEEF, 16'h0000, 32'd10));
		send_poll(mk_poll(1'b0, 4'd15, '1, '1, 32'd20));
		send_poll(mk_poll(1'b1, 4'd10, 64'h0123_4567_89AB_CDEF, 16'hA55A, 32'd30));
		write_reg(CFG_READER_ENABLED, 16'h0001);
	endtask

	// default debounce, then identifier compare with masking and clamping
	task automatic test_debounce_and_uid();
		send_poll(mk_poll(1'b1, 4'd7, 64'h00EE_DDCC_BBAA_9988, 16'h0000, 32'd1000));
		// exactly the debounce time is not enough, one more ms confirms
		send_poll(mk_poll(1'b1, 4'd7, 64'h00EE_DDCC_BBAA_9988, 16'h0000, 32'd1100));
		send_poll(mk_poll(1'b1, 4'd7, 64'h00EE_DDCC_BBAA_9988, 16'h0000, 32'd1101));
		// junk beyond the length must not count as a new tag
		send_poll(mk_poll(1'b1, 4'd7, 64'hFFEE_DDCC_BBAA_9988, 16'hFFFF, 32'd1150));
		// over-long length clamps to ten bytes: differs, so store then clear
		send_poll(mk_poll(1'b1, 4'd15, '1, '1, 32'd1160));
		send_poll(mk_poll(1'b1, 4'd15, '1, '1, 32'd1200));
		send_poll(mk_poll(1'b1, 4'd10, '1, '1, 32'd1261));
		// zero-length identifier against a ten-byte one
		send_poll(mk_poll(1'b1, 4'd0, 64'h1234, 16'h0000, 32'd1270));
		send_poll(mk_poll(1'b1, 4'd0, 64'hFFFF_0000_5555, 16'hBEEF, 32'd1400));
		// nine bytes: only the low byte of the high word takes part
		send_poll(mk_poll(1'b1, 4'd9, 64'h0807_0605_0403_0201, 16'hFF09, 32'd1410));
	endtask

	// three misses in a row drop a detected tag back to absent
	task automatic test_detected_misses();
		send_poll(mk_poll(1'b0, 4'd9, 64'h0807_0605_0403_0201, 16'h0009, 32'd1430));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd1440));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd1450));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd1460));
	endtask

	// removal by miss count, removed back to absent, removal by timeout
	task automatic test_removal();
		send_poll(mk_poll(1'b1, 4'd4, 64'h1122_3344, 16'h0000, 32'd5000));
		send_poll(mk_poll(1'b1, 4'd4, 64'h1122_3344, 16'h0000, 32'd5200));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd5210));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd5220));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd5230));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd5700));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd5701));
		send_poll(mk_poll(1'b1, 4'd4, 64'h1122_3344, 16'h0000, 32'd6000));
		send_poll(mk_poll(1'b1, 4'd4, 64'h1122_3344, 16'h0000, 32'd6200));
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd6701));
		send_poll(mk_poll(1'b1, 4'd4, 64'h1122_3344, 16'h0000, 32'd6702));
	endtask

	// fail limit of zero, with the debounce window straddling the clock wrap
	task automatic test_fail_limit_zero();
		write_reg(CFG_PRESENCE_FAIL_LIMIT, 16'h5A00);
		for (int k = 0; k < 3; k++)
			send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'd6710 + k));
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'hFFFF_FFC0));
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'h0000_0020));
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'h0000_0030));
		// a single miss is already at the limit
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'h0000_0031));
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'h0000_0040));
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'h0000_0200));
	endtask

	// switching the reader off freezes a present tag
	task automatic test_reader_toggle();
		write_reg(CFG_READER_ENABLED, 16'hFFFE);
		send_poll(mk_poll(1'b0, 4'd0, '0, '0, 32'h0000_5000));
		send_poll(mk_poll(1'b1, 4'd4, 64'h0BAD_F00D, 16'h0000, 32'h0000_5001));
		write_reg(CFG_READER_ENABLED, 16'h8001);
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'h0000_5002));
	endtask

	// largest fail limit and timeout: the miss count runs up to its ceiling
	task automatic test_miss_saturation();
		write_reg(CFG_PRESENCE_FAIL_LIMIT, 16'h00FF);
		write_reg(CFG_ABSENCE_TIMEOUT_MS, 16'hFFFF);
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'h0000_6000));
		for (int k = 1; k <= 262; k++)
			send_poll(mk_poll(1'b0, 4'($urandom), {$urandom, $urandom}, 16'($urandom),
				32'h0000_6000 + k));
		send_poll(mk_poll(1'b1, 4'd10, 64'hA1A2_A3A4_A5A6_A7A8, 16'hA9AA, 32'h0000_7000));
	endtask

	// next poll of a random tag session: mostly sightings of one tag at small
	// time steps, with misses, new tags, altered identifiers and clock jumps
	task automatic next_random_poll(output poll_t p);
		logic [63:0] m_lo;
		logic [15:0] m_hi;
		int          pick;
		int          kind;
		int          bit_idx;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			gen_ms += $urandom_range(0, cfg_debounce / 4 + 2);
		else if (pick < 95)
			gen_ms += $urandom_range(0, cfg_debounce + cfg_timeout + 2);
		else
			gen_ms = $urandom;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gen_len = 4'd4;
				3, 4:    gen_len = 4'd7;
				5, 6:    gen_len = 4'd10;
				default: gen_len = 4'($urandom_range(0, 15));
			endcase
			gen_lo = {$urandom, $urandom};
			gen_hi = 16'($urandom);
		end else if (kind < 10) begin
			case ($urandom_range(0, 2))
				0: begin
					bit_idx = $urandom_range(0, 63);
					gen_lo[bit_idx] = ~gen_lo[bit_idx];
				end
				1: begin
					bit_idx = $urandom_range(0, 15);
					gen_hi[bit_idx] = ~gen_hi[bit_idx];
				end
				default: gen_len = 4'($urandom_range(0, 15));
			endcase
		end
		m_lo = lo_bytes_mask(clamp_len(gen_len));
		m_hi = hi_bytes_mask(clamp_len(gen_len));
		p.tag_seen = (kind < 70);
		p.now_ms = gen_ms;
		if (p.tag_seen) begin
			// fresh junk above the length on every sighting
			p.uid_length = gen_len;
			p.uid_low = (gen_lo & m_lo) | ({$urandom, $urandom} & ~m_lo);
			p.uid_high = (gen_hi & m_hi) | (16'($urandom) & ~m_hi);
		end else begin
			p.uid_length = 4'($urandom);
			p.uid_low = {$urandom, $urandom};
			p.uid_high = 16'($urandom);
		end
	endtask

	// random phases: extreme settings first, then mixed ones, across the
	// three idling patterns
	task automatic test_random_traffic();
		logic [15:0] debounce;
		logic [15:0] fail_word;
		logic [15:0] timeout;
		poll_t       p;
		gen_ms = 32'hFFF0_0000;	// close enough to the top for the clock to wrap
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 9;
				recv_stall_pct = 64;
			end else if (ph < 4) begin
				send_idle_pct = 64;
				recv_stall_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case (ph)
				0: begin
					debounce = '0;
					fail_word = {8'($urandom), 8'd1};
					timeout = '0;
				end
				1: begin
					debounce = '1;
					fail_word = {8'($urandom), 8'd255};
					timeout = '1;
				end
				default: begin
					debounce = 16'($urandom_range(0, 300));
					fail_word = {8'($urandom), 8'($urandom_range(1, 6))};
					timeout = 16'($urandom_range(0, 1200));
				end
			endcase
			write_reg(CFG_READER_ENABLED, 16'($urandom) | 16'h0001);
			write_reg(CFG_DEBOUNCE_MS, debounce);
			write_reg(CFG_PRESENCE_FAIL_LIMIT, fail_word);
			write_reg(CFG_ABSENCE_TIMEOUT_MS, timeout);
			for (int n = 0; n < PHASE_POLLS; n++) begin
				next_random_poll(p);
				send_poll(p);
				// now and then the sender waits for the result stream to run dry
				if ($urandom_range(0, 99) == 0)
					wait_results_idle();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		// reset held from time zero, released on a falling edge, away from the rising edge
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_reader_disabled();
		test_debounce_and_uid();
		test_detected_misses();
		test_removal();
		test_fail_limit_zero();
		test_reader_toggle();
		test_miss_saturation();
		test_random_traffic();

		// drain, then give any stray beat time to show up
		wait_results_idle();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		if (fail_count == 0)
			$display("tb_tag_presence_tracker_top: clean");
		else
			$display("tb_tag_presence_tracker_top: errors");
		$finish;
	end

endmodule
